@@ hdl/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked property, also checked while reset is asserted.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ hdl/rmt_pkg.sv @@
// Shared types and constants of the range maximum tree.
package rmt_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 11;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  localparam logic signed [VAL_W-1:0] NEG_ONE = -32'sd1;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic   valid;
    value_t value;
  } result_t;

endpackage

@@ hdl/rmt_if.sv @@
// Input and result channel interfaces of the range maximum tree.
interface rmt_in_if;
  logic            valid;
  logic            ready;
  logic            mode;
  rmt_pkg::pos_t   position;
  rmt_pkg::value_t new_value;
  rmt_pkg::pos_t   range_low;
  rmt_pkg::pos_t   range_high;

  modport source (output valid, output mode, output position, output new_value,
                  output range_low, output range_high, input ready);
  modport sink (input valid, input mode, input position, input new_value,
                input range_low, input range_high, output ready);
endinterface

interface rmt_out_if;
  logic            valid;
  logic            ready;
  rmt_pkg::value_t range_max;

  modport source (output valid, output range_max, input ready);
  modport sink (input valid, input range_max, output ready);
endinterface

@@ hdl/range_max_tree_unit.sv @@
// Top level of the range maximum tree with point update.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    mode, position, new_value, range_low, range_high
//   out_ch   out  valid/ready    range_max (queries only)
//
// After reset the node memory is swept to -1 at every address from 0 to 2*SIZE-1;
// no transaction is taken meanwhile. An update writes the leaf and then each
// ancestor up to the root, and a query folds nodes from its range bounds up: the
// single node memory port serves one read or one write per cycle, and each tree level needs a read and a fold or write.
// A finished result waits in the output register; a stalled output only holds
// a query in its output state, and no new transaction is taken meanwhile.
module range_max_tree_unit #(
  parameter int SIZE = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  rmt_in_if.sink   in_ch,
  rmt_out_if.source out_ch
);

  localparam int IW = $clog2(2 * SIZE);

  rmt_pkg::result_t res;
  logic             out_free;
  logic             mem_we;
  logic [IW-1:0]    mem_addr;
  rmt_pkg::value_t  mem_wdata;
  rmt_pkg::value_t  mem_rdata;
  logic             out_valid_r;
  rmt_pkg::value_t  out_data_r;

  rmt_seq #(.SIZE(SIZE)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_free  (out_free),
    .res       (res),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  rmt_node_ram #(.DEPTH(2 * SIZE)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data_r <= res.value;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.range_max = out_data_r;

endmodule

@@ hdl/rmt_node_ram.sv @@
// Single-port node memory with registered read data.
module rmt_node_ram #(
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   addr,
  input  rmt_pkg::value_t wdata,
  output rmt_pkg::value_t rdata
);

  rmt_pkg::value_t mem [DEPTH];
  rmt_pkg::value_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/rmt_seq.sv @@
// Sequencer and shared max unit that walk the tree through one memory port.
module rmt_seq #(
  parameter int SIZE = 1024,
  localparam int IW = $clog2(2 * SIZE),
  localparam int CW = $clog2(2 * SIZE + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  rmt_in_if.sink            in_ch,
  input  logic              out_free,
  output rmt_pkg::result_t  res,
  output logic              mem_we,
  output logic [IW-1:0]     mem_addr,
  output rmt_pkg::value_t   mem_wdata,
  input  rmt_pkg::value_t   mem_rdata
);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_U_RD  = 3'd2;
  localparam logic [2:0] ST_U_UP  = 3'd3;
  localparam logic [2:0] ST_Q_L   = 3'd4;
  localparam logic [2:0] ST_Q_R   = 3'd5;
  localparam logic [2:0] ST_Q_OUT = 3'd6;

  localparam logic [IW-1:0] LAST_IX = IW'(2 * SIZE - 1);
  localparam logic [IW-1:0] ROOT_IX = IW'(1);

  logic [2:0]      state_r, state_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   l_r, l_nxt;
  logic [CW-1:0]   r_r, r_nxt;
  rmt_pkg::value_t acc_r, acc_nxt;
  logic            rd_pend_r, rd_pend_nxt;

  rmt_pkg::value_t cmp_max;
  rmt_pkg::value_t upd_val;
  logic [31:0]     lo_c;
  logic [31:0]     hi_c;
  logic            pos_ok;
  logic [IW-1:0]   leaf_ix;
  logic [CW-1:0]   l_init;
  logic [CW-1:0]   r_init;
  logic [CW-1:0]   r_dec;
  logic            accept;

  assign cmp_max = (rd_pend_r && (mem_rdata > acc_r)) ? mem_rdata : acc_r;
  assign upd_val = (in_ch.new_value < rmt_pkg::NEG_ONE) ? rmt_pkg::NEG_ONE
                                                         : in_ch.new_value;
  assign pos_ok  = (in_ch.position != '0) && (32'(in_ch.position) <= 32'(SIZE));
  assign leaf_ix = IW'(32'(SIZE) + 32'(in_ch.position) - 32'd1);
  assign lo_c    = (in_ch.range_low == '0) ? 32'd1 : 32'(in_ch.range_low);
  assign hi_c    = (32'(in_ch.range_high) > 32'(SIZE)) ? 32'(SIZE)
                                                       : 32'(in_ch.range_high);
  assign l_init  = CW'(32'(SIZE) + lo_c - 32'd1);
  assign r_init  = CW'(32'(SIZE) + hi_c);
  assign r_dec   = r_r - CW'(1);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    l_nxt       = l_r;
    r_nxt       = r_r;
    acc_nxt     = cmp_max;
    rd_pend_nxt = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = idx_r;
    mem_wdata   = cmp_max;
    res.valid   = 1'b0;
    res.value   = acc_r;
    unique case (state_r)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = rmt_pkg::NEG_ONE;
        idx_nxt   = idx_r + IW'(1);
        if (idx_r == LAST_IX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.mode == rmt_pkg::MODE_UPDATE) begin
            acc_nxt   = upd_val;
            state_nxt = ST_U_RD;
            if (pos_ok) begin
              mem_we    = 1'b1;
              mem_addr  = leaf_ix;
              mem_wdata = upd_val;
              idx_nxt   = leaf_ix;
            end else begin
              idx_nxt = ROOT_IX;
            end
          end else begin
            acc_nxt = rmt_pkg::NEG_ONE;
            if (lo_c > hi_c) begin
              state_nxt = ST_Q_OUT;
            end else begin
              l_nxt     = l_init;
              r_nxt     = r_init;
              state_nxt = ST_Q_L;
            end
          end
        end
      end
      ST_U_RD: begin
        if (idx_r == ROOT_IX) begin
          state_nxt = ST_IDLE;
        end else begin
          mem_addr    = idx_r ^ ROOT_IX;
          rd_pend_nxt = 1'b1;
          state_nxt   = ST_U_UP;
        end
      end
      ST_U_UP: begin
        mem_we    = 1'b1;
        mem_addr  = idx_r >> 1;
        idx_nxt   = idx_r >> 1;
        state_nxt = ST_U_RD;
      end
      ST_Q_L: begin
        if (l_r < r_r) begin
          if (l_r[0]) begin
            mem_addr    = l_r[IW-1:0];
            rd_pend_nxt = 1'b1;
            l_nxt       = l_r + CW'(1);
          end
          state_nxt = ST_Q_R;
        end else begin
          state_nxt = ST_Q_OUT;
        end
      end
      ST_Q_R: begin
        l_nxt = l_r >> 1;
        if (r_r[0]) begin
          mem_addr    = r_dec[IW-1:0];
          rd_pend_nxt = 1'b1;
          r_nxt       = r_dec >> 1;
        end else begin
          r_nxt = r_r >> 1;
        end
        state_nxt = ST_Q_L;
      end
      ST_Q_OUT: begin
        if (out_free) begin
          res.valid = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      idx_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    l_r   <= l_nxt;
    r_r   <= r_nxt;
    acc_r <= acc_nxt;
  end

endmodule

@@ hdl/rmt_checker.sv @@
// Port-level checker of the range maximum tree, bound to the top level.
`include "assert_macros.svh"

module rmt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  `ASSERT_CLK_ALWAYS(a_reset_quiet, clk, !rst_n |=> (!out_valid && !in_ready))
  `ASSERT_CLK(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
  `ASSERT_CLK(a_no_instant_result, clk, rst_n, (in_valid && in_ready) |=> !$rose(out_valid))
  `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid)

endmodule

bind range_max_tree_unit rmt_checker u_rmt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
